// ===== src/dsdf_pkg.sv =====
`timescale 1ns / 1ps

package dsdf_pkg;

   localparam int MAX_SOURCE_DIM = 256;
   localparam int DOWNSCALE      = 16;
   localparam int SEARCH_CAP     = 128;

   localparam int COORD_W = 8;                  // bits of one source coordinate
   localparam int ADDR_W  = 2 * COORD_W;        // bit store address
   localparam int DIM_W   = 9;                  // width and height registers
   localparam int POS_W   = 10;                 // signed working coordinates
   localparam int DSQ_W   = 16;                 // squared distance
   localparam int ROOT_W  = 8;                  // floor square root of DSQ_W bits

   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 9;

   localparam logic [CSR_IDX_W-1:0] CSR_SOURCE_WIDTH   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SOURCE_HEIGHT  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_WRAP_ENABLE    = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_GRAY_THRESHOLD = 2'd3;

   localparam logic KIND_LOAD  = 1'b0;
   localparam logic KIND_QUERY = 1'b1;

   localparam logic [7:0] CODE_MID_BG = 8'd128;
   localparam logic [7:0] CODE_MID_FG = 8'd127;
   localparam logic [7:0] CODE_MAX    = 8'd255;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_NORM,
      ST_CTR_RD,
      ST_CTR_WT,
      ST_SCAN,
      ST_DRAIN,
      ST_ROOT,
      ST_OUT
   } state_type;

endpackage

// ===== src/dsdf_isqrt.sv =====
`timescale 1ns / 1ps

module dsdf_isqrt (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic [dsdf_pkg::DSQ_W-1:0]   value,
   output logic                         done,
   output logic [dsdf_pkg::ROOT_W-1:0]  root
);
   import dsdf_pkg::*;

   logic             busy_ff, busy_in;
   logic [DSQ_W-1:0] v_ff, v_in;
   logic [DSQ_W-1:0] r_ff, r_in;
   logic [DSQ_W-1:0] bit_ff, bit_in;
   logic [DSQ_W-1:0] trial;

   // One result bit per cycle, digit by digit.
   always_comb begin
      trial   = r_ff + bit_ff;
      busy_in = busy_ff;
      v_in    = v_ff;
      r_in    = r_ff;
      bit_in  = bit_ff;
      done    = busy_ff && (bit_ff == '0);
      if (start) begin
         busy_in = 1'b1;
         v_in    = value;
         r_in    = '0;
         bit_in  = DSQ_W'(1) << (DSQ_W - 2);
      end else if (busy_ff) begin
         if (bit_ff == '0) begin
            busy_in = 1'b0;
         end else begin
            if (v_ff >= trial) begin
               v_in = v_ff - trial;
               r_in = (r_ff >> 1) + bit_ff;
            end else begin
               r_in = r_ff >> 1;
            end
            bit_in = bit_ff >> 2;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
      v_ff   <= v_in;
      r_ff   <= r_in;
      bit_ff <= bit_in;
   end

   assign root = r_ff[ROOT_W-1:0];

endmodule

// ===== src/downscaled_signed_distance_field.sv =====
`timescale 1ns / 1ps
// Channel   Direction  Handshake              Payload
// req       in         req_valid / req_stall  kind, pixel_x/y, gray_value, cell_x/y
// rsp       out        rsp_valid / rsp_stall  distance_code, found
// csr       in         csr_write              csr_index, csr_data
//
// A load is written to the bit store without leaving idle. A query scans a (2R+1)^2 window,
// where R = min(max(w,h),128), after the coordinate wrap setup; the scan is paced
// by the single read port of the bit store, which delivers one pixel per cycle.
// The bit store has no reset; reset clears only control state and the CSR registers.
// A stalled result is held in the output register; the next request is taken meanwhile.

module downscaled_signed_distance_field (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic                                req_kind,
   input  logic [7:0]                          req_pixel_x,
   input  logic [7:0]                          req_pixel_y,
   input  logic [7:0]                          req_gray_value,
   input  logic [3:0]                          req_cell_x,
   input  logic [3:0]                          req_cell_y,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [7:0]                          rsp_distance_code,
   output logic                                rsp_found,
   input  logic                                csr_write,
   input  logic [dsdf_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [dsdf_pkg::CSR_DATA_W-1:0]     csr_data
);
   import dsdf_pkg::*;

   state_type state_ff, state_in;

   logic [DIM_W-1:0] width_ff, height_ff;
   logic             wrap_ff;
   logic [7:0]       thresh_ff;

   logic [DIM_W-1:0] eff_w, eff_h, big_dim, radius;
   logic signed [POS_W-1:0] sw, sh, sr;

   logic signed [POS_W-1:0] cx_ff, cx_in, cy_ff, cy_in;
   logic signed [POS_W-1:0] ncx_ff, ncx_in, ncy_ff, ncy_in;
   logic signed [POS_W-1:0] nx_ff, nx_in, ny_ff, ny_in;
   logic signed [POS_W-1:0] dx_ff, dx_in, dy_ff, dy_in;
   logic signed [POS_W-1:0] ax_ff, ax_in, ay_ff, ay_in;
   logic [COORD_W-1:0]      xw_ff, xw_in, yw_ff, yw_in;

   logic                    p_live_ff, p_live_in, p_ok_ff, p_ok_in;
   logic signed [POS_W-1:0] p_dx_ff, p_dx_in, p_dy_ff, p_dy_in;
   logic                    ctr_fg_ff, ctr_fg_in;
   logic                    found_ff, found_in;
   logic [DSQ_W-1:0]        best_ff, best_in;
   logic [ROOT_W-1:0]       d_ff, d_in;

   logic             rsp_valid_ff, rsp_valid_in;
   logic [7:0]       rsp_code_ff, rsp_code_in;
   logic             rsp_found_ff, rsp_found_in;

   logic                    store_mem [0:(1 << ADDR_W) - 1];
   logic                    rd_ff;
   logic                    mem_we, mem_wdata;
   logic [ADDR_W-1:0]       mem_waddr, mem_raddr;

   logic                    req_take, norm_done, scan_ok, ctr_ok, hit, last_step;
   logic signed [POS_W-1:0] cx_q, cy_q;
   logic [COORD_W-1:0]      ux, uy;
   logic [DSQ_W-1:0]        dsq;
   logic [DIM_W-1:0]        xw_next, yw_next, code_sum;

   logic              root_start, root_done;
   logic [ROOT_W-1:0] root_val;

   // The root starts while the last scanned pixel is still being compared.
   dsdf_isqrt u_isqrt (
      .clock (clock),
      .reset (reset),
      .start (root_start),
      .value (best_in),
      .done  (root_done),
      .root  (root_val)
   );

   function automatic logic signed [POS_W-1:0] wrap_step(logic signed [POS_W-1:0] v,
                                                        logic signed [POS_W-1:0] lim);
      if (v < 0) begin
         return v + lim;
      end else if (v >= lim) begin
         return v - lim;
      end
      return v;
   endfunction

   function automatic logic in_range(logic signed [POS_W-1:0] v,
                                     logic signed [POS_W-1:0] lim);
      return (v >= 0) && (v < lim);
   endfunction

   always_comb begin
      eff_w   = (width_ff == '0) ? DIM_W'(1)
              : (width_ff > DIM_W'(MAX_SOURCE_DIM)) ? DIM_W'(MAX_SOURCE_DIM) : width_ff;
      eff_h   = (height_ff == '0) ? DIM_W'(1)
              : (height_ff > DIM_W'(MAX_SOURCE_DIM)) ? DIM_W'(MAX_SOURCE_DIM) : height_ff;
      big_dim = (eff_w > eff_h) ? eff_w : eff_h;
      radius  = (big_dim > DIM_W'(SEARCH_CAP)) ? DIM_W'(SEARCH_CAP) : big_dim;
      sw      = $signed(POS_W'(eff_w));
      sh      = $signed(POS_W'(eff_h));
      sr      = $signed(POS_W'(radius));
   end

   assign req_take  = req_valid && !req_stall;
   assign req_stall = (state_ff != ST_IDLE);
   assign cx_q      = $signed(POS_W'(req_cell_x) * POS_W'(DOWNSCALE)) - POS_W'(DOWNSCALE / 2);
   assign cy_q      = $signed(POS_W'(req_cell_y) * POS_W'(DOWNSCALE)) - POS_W'(DOWNSCALE / 2);

   assign norm_done = in_range(ncx_ff, sw) && in_range(ncy_ff, sh)
                   && in_range(nx_ff, sw) && in_range(ny_ff, sh);
   assign scan_ok   = wrap_ff || (in_range(ax_ff, sw) && in_range(ay_ff, sh));
   assign ctr_ok    = wrap_ff || (in_range(cx_ff, sw) && in_range(cy_ff, sh));
   assign last_step = (dx_ff == sr) && (dy_ff == sr);
   assign xw_next   = DIM_W'(xw_ff) + DIM_W'(1);
   assign yw_next   = DIM_W'(yw_ff) + DIM_W'(1);

   // Second stage of the scan: class of the pixel read last cycle against the centre.
   always_comb begin
      ux  = p_dx_ff[POS_W-1] ? COORD_W'(-p_dx_ff) : COORD_W'(p_dx_ff);
      uy  = p_dy_ff[POS_W-1] ? COORD_W'(-p_dy_ff) : COORD_W'(p_dy_ff);
      dsq = DSQ_W'(ux * ux) + DSQ_W'(uy * uy);
      hit = p_live_ff && ((p_ok_ff && rd_ff) != ctr_fg_ff);
   end

   always_comb begin
      mem_we    = 1'b0;
      mem_waddr = {req_pixel_y, req_pixel_x};
      mem_wdata = (req_gray_value >= thresh_ff);
      if (state_ff == ST_CTR_RD) begin
         mem_raddr = wrap_ff ? {ncy_ff[COORD_W-1:0], ncx_ff[COORD_W-1:0]}
                             : {cy_ff[COORD_W-1:0], cx_ff[COORD_W-1:0]};
      end else begin
         mem_raddr = wrap_ff ? {yw_ff, xw_ff} : {ay_ff[COORD_W-1:0], ax_ff[COORD_W-1:0]};
      end

      state_in     = state_ff;
      cx_in = cx_ff;   cy_in = cy_ff;
      ncx_in = ncx_ff; ncy_in = ncy_ff;
      nx_in = nx_ff;   ny_in = ny_ff;
      dx_in = dx_ff;   dy_in = dy_ff;
      ax_in = ax_ff;   ay_in = ay_ff;
      xw_in = xw_ff;   yw_in = yw_ff;
      p_live_in    = 1'b0;
      p_ok_in      = 1'b0;
      p_dx_in      = dx_ff;
      p_dy_in      = dy_ff;
      ctr_fg_in    = ctr_fg_ff;
      found_in     = found_ff;
      best_in      = best_ff;
      d_in         = d_ff;
      root_start   = 1'b0;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_code_in  = rsp_code_ff;
      rsp_found_in = rsp_found_ff;
      code_sum     = DIM_W'(CODE_MID_FG) + DIM_W'(d_ff);

      if (hit && (!found_ff || dsq < best_ff)) begin
         best_in  = dsq;
         found_in = 1'b1;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               if (req_kind == KIND_LOAD) begin
                  mem_we = 1'b1;
               end else begin
                  cx_in    = cx_q;
                  cy_in    = cy_q;
                  ncx_in   = cx_q;
                  ncy_in   = cy_q;
                  nx_in    = cx_q - sr;
                  ny_in    = cy_q - sr;
                  ax_in    = cx_q - sr;
                  ay_in    = cy_q - sr;
                  dx_in    = -sr;
                  dy_in    = -sr;
                  found_in = 1'b0;
                  best_in  = '0;
                  state_in = ST_NORM;
               end
            end
         end
         ST_NORM: begin
            // Bring the centre and the scan start into the image for wrapping.
            ncx_in = wrap_step(ncx_ff, sw);
            ncy_in = wrap_step(ncy_ff, sh);
            nx_in  = wrap_step(nx_ff, sw);
            ny_in  = wrap_step(ny_ff, sh);
            if (norm_done) begin
               xw_in    = nx_ff[COORD_W-1:0];
               yw_in    = ny_ff[COORD_W-1:0];
               state_in = ST_CTR_RD;
            end
         end
         ST_CTR_RD: begin
            p_ok_in  = ctr_ok;
            state_in = ST_CTR_WT;
         end
         ST_CTR_WT: begin
            ctr_fg_in = p_ok_ff && rd_ff;
            state_in  = ST_SCAN;
         end
         ST_SCAN: begin
            p_live_in = 1'b1;
            p_ok_in   = scan_ok;
            if (dx_ff == sr) begin
               dx_in = -sr;
               ax_in = cx_ff - sr;
               xw_in = nx_ff[COORD_W-1:0];
               dy_in = dy_ff + POS_W'(1);
               ay_in = ay_ff + POS_W'(1);
               yw_in = (yw_next == eff_h) ? '0 : yw_next[COORD_W-1:0];
            end else begin
               dx_in = dx_ff + POS_W'(1);
               ax_in = ax_ff + POS_W'(1);
               xw_in = (xw_next == eff_w) ? '0 : xw_next[COORD_W-1:0];
            end
            if (last_step) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            root_start = 1'b1;
            state_in   = ST_ROOT;
         end
         ST_ROOT: begin
            if (root_done) begin
               d_in     = root_val;
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_found_in = found_ff;
               if (ctr_fg_ff) begin
                  rsp_code_in = !found_ff ? CODE_MAX
                              : (code_sum > DIM_W'(CODE_MAX)) ? CODE_MAX : code_sum[7:0];
               end else begin
                  rsp_code_in = (!found_ff || d_ff > ROOT_W'(CODE_MID_BG)) ? 8'd0
                              : CODE_MID_BG - 8'(d_ff);
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         store_mem[mem_waddr] <= mem_wdata;
      end
      rd_ff <= store_mem[mem_raddr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         p_live_ff    <= 1'b0;
         width_ff     <= DIM_W'(256);
         height_ff    <= DIM_W'(256);
         wrap_ff      <= 1'b0;
         thresh_ff    <= 8'd128;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         p_live_ff    <= p_live_in;
         if (csr_write) begin
            case (csr_index)
               CSR_SOURCE_WIDTH:   width_ff  <= csr_data;
               CSR_SOURCE_HEIGHT:  height_ff <= csr_data;
               CSR_WRAP_ENABLE:    wrap_ff   <= csr_data[0];
               CSR_GRAY_THRESHOLD: thresh_ff <= csr_data[7:0];
               default: begin
               end
            endcase
         end
      end
      cx_ff <= cx_in;   cy_ff <= cy_in;
      ncx_ff <= ncx_in; ncy_ff <= ncy_in;
      nx_ff <= nx_in;   ny_ff <= ny_in;
      dx_ff <= dx_in;   dy_ff <= dy_in;
      ax_ff <= ax_in;   ay_ff <= ay_in;
      xw_ff <= xw_in;   yw_ff <= yw_in;
      p_ok_ff      <= p_ok_in;
      p_dx_ff      <= p_dx_in;
      p_dy_ff      <= p_dy_in;
      ctr_fg_ff    <= ctr_fg_in;
      found_ff     <= found_in;
      best_ff      <= best_in;
      d_ff         <= d_in;
      rsp_code_ff  <= rsp_code_in;
      rsp_found_ff <= rsp_found_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_distance_code = rsp_code_ff;
   assign rsp_found         = rsp_found_ff;

endmodule
